// ----- rtl/core/ssp_pkg.sv -----
package ssp_pkg;

    localparam int PULSE_W    = 12;
    localparam int TIME_W     = 32;
    localparam int FRAC_W     = 17;
    localparam int TABLE_W    = 60;
    localparam int CFG_IDX_W  = 3;
    localparam int LANE_MAX   = 5;

    localparam int SERVO_COUNT_DEF   = 5;
    localparam int FRACTION_BITS_DEF = 16;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_SET  = 1'b1;

    // servo i sits at bits 12i of each table
    localparam logic [TABLE_W-1:0] OPEN_RESET  = 60'd281543712968705000;
    localparam logic [TABLE_W-1:0] CLOSE_RESET = 60'd534936493292507500;
    localparam logic [PULSE_W-1:0] STEP_RESET    = 12'd10;
    localparam logic [TIME_W-1:0]  TIMEOUT_RESET = 32'd500;
    localparam logic [PULSE_W-1:0] FLOOR_RESET   = 12'd500;
    localparam logic [PULSE_W-1:0] CEIL_RESET    = 12'd2500;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OPEN_TABLE  = 3'd0,
        CFG_CLOSE_TABLE = 3'd1,
        CFG_STEP_LIMIT  = 3'd2,
        CFG_TIMEOUT     = 3'd3,
        CFG_FLOOR       = 3'd4,
        CFG_CEILING     = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic              kind;
        logic [TIME_W-1:0] time_ms;
        logic [FRAC_W-1:0] fraction_0;
        logic [FRAC_W-1:0] fraction_1;
        logic [FRAC_W-1:0] fraction_2;
        logic [FRAC_W-1:0] fraction_3;
        logic [FRAC_W-1:0] fraction_4;
    } t_in;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse_0;
        logic [PULSE_W-1:0] pulse_1;
        logic [PULSE_W-1:0] pulse_2;
        logic [PULSE_W-1:0] pulse_3;
        logic [PULSE_W-1:0] pulse_4;
        logic               timed_out;
    } t_out;

    typedef struct packed {
        logic [TABLE_W-1:0] open_table;
        logic [TABLE_W-1:0] close_table;
        logic [PULSE_W-1:0] step_limit;
        logic [TIME_W-1:0]  timeout_ms;
        logic [PULSE_W-1:0] pulse_floor;
        logic [PULSE_W-1:0] pulse_ceiling;
    } t_cfg;

    typedef struct packed {
        logic set_en;
        logic tick_en;
        logic stale;
    } t_lane_ctl;

endpackage

// ----- rtl/core/ssp_cfg.sv -----
module ssp_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ssp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ssp_pkg::TABLE_W-1:0]         i_cfg_data,
    output ssp_pkg::t_cfg                       o_cfg
);

    ssp_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.open_table    <= ssp_pkg::OPEN_RESET;
            r_cfg.close_table   <= ssp_pkg::CLOSE_RESET;
            r_cfg.step_limit    <= ssp_pkg::STEP_RESET;
            r_cfg.timeout_ms    <= ssp_pkg::TIMEOUT_RESET;
            r_cfg.pulse_floor   <= ssp_pkg::FLOOR_RESET;
            r_cfg.pulse_ceiling <= ssp_pkg::CEIL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ssp_pkg::CFG_OPEN_TABLE:  r_cfg.open_table  <= i_cfg_data;
                ssp_pkg::CFG_CLOSE_TABLE: r_cfg.close_table <= i_cfg_data;
                ssp_pkg::CFG_STEP_LIMIT:
                    r_cfg.step_limit <= i_cfg_data[ssp_pkg::PULSE_W-1:0];
                ssp_pkg::CFG_TIMEOUT:
                    r_cfg.timeout_ms <= i_cfg_data[ssp_pkg::TIME_W-1:0];
                ssp_pkg::CFG_FLOOR:
                    r_cfg.pulse_floor <= i_cfg_data[ssp_pkg::PULSE_W-1:0];
                ssp_pkg::CFG_CEILING:
                    r_cfg.pulse_ceiling <= i_cfg_data[ssp_pkg::PULSE_W-1:0];
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/core/ssp_lane.sv -----
module ssp_lane #(
    parameter int                            FRACTION_BITS = ssp_pkg::FRACTION_BITS_DEF,
    parameter logic [ssp_pkg::PULSE_W-1:0]   RESET_PULSE   = 12'd1000
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ssp_pkg::t_lane_ctl               i_ctl,
    input  logic [ssp_pkg::FRAC_W-1:0]       i_frac,
    input  logic [ssp_pkg::PULSE_W-1:0]      i_open,
    input  logic [ssp_pkg::PULSE_W-1:0]      i_close,
    input  logic [ssp_pkg::PULSE_W-1:0]      i_step,
    input  logic [ssp_pkg::PULSE_W-1:0]      i_floor,
    input  logic [ssp_pkg::PULSE_W-1:0]      i_ceiling,
    output logic [ssp_pkg::PULSE_W-1:0]      o_pulse
);

    localparam int PW = ssp_pkg::PULSE_W;
    localparam int FW = (FRACTION_BITS + 1 > ssp_pkg::FRAC_W) ?
                        FRACTION_BITS + 1 : ssp_pkg::FRAC_W;
    localparam int MW = PW + FW;
    localparam logic [FW-1:0] ONE = FW'(1) << FRACTION_BITS;

    logic [PW-1:0] r_current;
    logic [PW-1:0] r_target;
    logic [PW-1:0] n_current;
    logic [PW-1:0] n_target;

    logic [FW-1:0] w_frac_ext;
    logic [FW-1:0] w_frac_sat;
    logic          w_closing_up;
    logic [PW-1:0] w_span;
    logic [MW-1:0] w_prod;
    logic [PW-1:0] w_mag;
    logic [PW-1:0] w_set_target;
    logic [PW-1:0] w_tick_target;
    logic [PW-1:0] w_diff;
    logic [PW-1:0] w_move;

    // set beat: target from the closure fraction
    always_comb begin
        w_frac_ext   = FW'(i_frac);
        w_frac_sat   = (w_frac_ext > ONE) ? ONE : w_frac_ext;
        w_closing_up = (i_close >= i_open);
        w_span       = w_closing_up ? (i_close - i_open) : (i_open - i_close);
        w_prod       = MW'(w_span) * MW'(w_frac_sat);
        w_mag        = w_prod[FRACTION_BITS +: PW];
        w_set_target = w_closing_up ? (i_open + w_mag) : (i_open - w_mag);
    end

    // tick beat: stale command sends target back to open, then slew
    always_comb begin
        w_tick_target = i_ctl.stale ? i_open : r_target;
        if (r_current < w_tick_target) begin
            w_diff    = w_tick_target - r_current;
            w_move    = (w_diff > i_step) ? i_step : w_diff;
            n_current = r_current + w_move;
        end else begin
            w_diff    = r_current - w_tick_target;
            w_move    = (w_diff > i_step) ? i_step : w_diff;
            n_current = r_current - w_move;
        end
        n_target = i_ctl.set_en ? w_set_target : w_tick_target;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_current <= RESET_PULSE;
            r_target  <= RESET_PULSE;
        end else if (i_ctl.set_en) begin
            r_target <= n_target;
        end else if (i_ctl.tick_en) begin
            r_target  <= n_target;
            r_current <= n_current;
        end
    end

    // floor test first, so crossed bounds give the floor
    always_comb begin
        if (n_current < i_floor)
            o_pulse = i_floor;
        else if (n_current > i_ceiling)
            o_pulse = i_ceiling;
        else
            o_pulse = n_current;
    end

endmodule

// ----- rtl/core/servo_slew_limited_positioner_unit.sv -----
// A tick beat is captured in the input register, and its result is then written to the output register.
// Throughput: one beat per cycle; a result waiting in the output register stalls intake
// only when the next beat is also a tick. Set beats produce no result.
// Reset (synchronous, active low): config registers take their defaults, every servo's
// current and target width go to the default open width, last command time to zero.
module servo_slew_limited_positioner_unit #(
    parameter int SERVO_COUNT   = ssp_pkg::SERVO_COUNT_DEF,
    parameter int FRACTION_BITS = ssp_pkg::FRACTION_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  ssp_pkg::t_in                    i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output ssp_pkg::t_out                   o_out_data,
    input  logic                            i_cfg_we,
    input  logic [ssp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ssp_pkg::TABLE_W-1:0]     i_cfg_data
);

    localparam int PW = ssp_pkg::PULSE_W;

    ssp_pkg::t_cfg      w_cfg;
    ssp_pkg::t_lane_ctl w_ctl;

    logic               r_in_valid;
    ssp_pkg::t_in       r_in;
    logic               r_out_valid;
    ssp_pkg::t_out      r_out;
    ssp_pkg::t_out      n_out;
    logic [ssp_pkg::TIME_W-1:0] r_last_cmd;
    logic [ssp_pkg::TIME_W-1:0] w_elapsed;
    logic               w_advance;

    logic [ssp_pkg::FRAC_W-1:0] w_frac  [ssp_pkg::LANE_MAX];
    logic [PW-1:0]              w_pulse [ssp_pkg::LANE_MAX];

    ssp_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // a set beat always moves on; a tick beat needs room in the output register
    assign w_advance  = r_in_valid &&
                        ((r_in.kind == ssp_pkg::KIND_SET) || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    assign w_elapsed     = r_in.time_ms - r_last_cmd;
    assign w_ctl.set_en  = w_advance && (r_in.kind == ssp_pkg::KIND_SET);
    assign w_ctl.tick_en = w_advance && (r_in.kind == ssp_pkg::KIND_TICK);
    assign w_ctl.stale   = (w_elapsed > w_cfg.timeout_ms);

    assign w_frac[0] = r_in.fraction_0;
    assign w_frac[1] = r_in.fraction_1;
    assign w_frac[2] = r_in.fraction_2;
    assign w_frac[3] = r_in.fraction_3;
    assign w_frac[4] = r_in.fraction_4;

    for (genvar g = 0; g < ssp_pkg::LANE_MAX; g++) begin : g_lane
        if (g < SERVO_COUNT) begin : g_used
            ssp_lane #(
                .FRACTION_BITS (FRACTION_BITS),
                .RESET_PULSE   (ssp_pkg::OPEN_RESET[PW*g +: PW])
            ) u_lane (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (w_ctl),
                .i_frac    (w_frac[g]),
                .i_open    (w_cfg.open_table[PW*g +: PW]),
                .i_close   (w_cfg.close_table[PW*g +: PW]),
                .i_step    (w_cfg.step_limit),
                .i_floor   (w_cfg.pulse_floor),
                .i_ceiling (w_cfg.pulse_ceiling),
                .o_pulse   (w_pulse[g])
            );
        end else begin : g_unused
            assign w_pulse[g] = '0;
        end
    end

    always_comb begin
        n_out.pulse_0   = w_pulse[0];
        n_out.pulse_1   = w_pulse[1];
        n_out.pulse_2   = w_pulse[2];
        n_out.pulse_3   = w_pulse[3];
        n_out.pulse_4   = w_pulse[4];
        n_out.timed_out = w_ctl.stale;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_last_cmd  <= '0;
        end else begin
            if (o_in_ready)
                r_in_valid <= i_in_valid;
            if (w_ctl.tick_en)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
            if (w_ctl.set_en)
                r_last_cmd <= r_in.time_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready)
            r_in <= i_in_data;
        if (w_ctl.tick_en)
            r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/core/ssp_checker.sv -----
module ssp_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            o_in_ready,
    input  ssp_pkg::t_in                    i_in_data,
    input  logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  ssp_pkg::t_out                   o_out_data
);

    // hold a result beat, unchanged, until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat dropped or changed before it was taken");

    // hold an input beat, unchanged, until it is taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input beat dropped or changed before it was taken");

    // intake stalls only behind a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled while output side was free");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_reset_in: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("input not ready after reset");

endmodule

bind servo_slew_limited_positioner_unit ssp_checker u_ssp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
